### hw/rtl/smaavg_pkg.sv
// Shared constants, types and the controller state encoding for the moving average block.
// No dependencies; imported by every module of the block except the RAM.
package smaavg_pkg;

	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int OUT_WIDTH    = 32;
	localparam int CFG_WIDTH    = 7;
	localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
	localparam int SUM_BITS     = SAMPLE_WIDTH + SLOT_BITS;
	localparam int EFF_BITS     = $clog2(MAX_WINDOW + 1);
	localparam int SEEN_BITS    = $clog2(MAX_WINDOW + 2);
	localparam int CNT_BITS     = $clog2(SUM_BITS + 1);
	localparam int PADDR_BITS   = 3;

	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = CFG_WIDTH'(5);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic                start;
		logic [SUM_BITS-1:0] dividend;
		logic [EFF_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [SUM_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

### hw/rtl/smaavg_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
// No dependencies.
module smaavg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/smaavg_div.sv
// Bit-serial restoring divider: unsigned window sum magnitude over the window length.
// Depends on smaavg_pkg.
module smaavg_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smaavg_pkg::div_req_t  req,
	output smaavg_pkg::div_rsp_t  rsp
);
	import smaavg_pkg::*;

	logic [SUM_BITS-1:0] quot_q;
	logic [EFF_BITS-1:0] rem_q;
	logic [EFF_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [EFF_BITS:0]   rem_shift;
	logic                fits;
	logic [EFF_BITS:0]   rem_sub;

	always_comb begin
		rem_shift = {rem_q, quot_q[SUM_BITS-1]};
		fits      = rem_shift >= {1'b0, dvs_q};
		rem_sub   = rem_shift - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(SUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[SUM_BITS-2:0], fits};
			rem_q  <= fits ? rem_sub[EFF_BITS-1:0] : rem_shift[EFF_BITS-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

### hw/rtl/simple_moving_average.sv
// Simple moving average over a stream of signed Q24.8 samples, top level.
// Depends on smaavg_pkg, smaavg_ram and smaavg_div.
//
// Usage
//   Input channel (in_valid/in_ready): one beat carries a sample and its
//   last_of_series flag. Output channel (out_valid/out_ready): one beat per
//   input beat, the average and window_full. Results come out in input order.
//   Position n of a series (from zero) gives the mean of the last window_length
//   samples, truncated toward zero, once n >= window_length; earlier positions
//   pass the sample through with window_full low.
//   Configuration: APB write to address 0 sets window_length (0 acts as 1,
//   above 64 acts as 64). Write only between series while the block is idle.
// Timing
//   One beat in flight at a time. A pass-through beat moves from acceptance
//   through ST_READ and ST_DONE into the output register; a window mean also
//   waits in ST_DIV for the one-bit-per-cycle divider. The next beat is
//   accepted in the cycle after the result moves into the output register.
// Reset
//   arst_n clears position count, running sum, ring pointer and the output
//   valid flag; window_length returns to 5. The ring memory is not cleared.
// Stall
//   A held result sits in the output register; the block still takes and
//   works one new beat, then waits in its done state until out_ready.
module simple_moving_average (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// input channel
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [smaavg_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                      last_of_series,
	// output channel
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [smaavg_pkg::OUT_WIDTH-1:0]    average,
	output logic                                      window_full,
	// APB configuration
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [smaavg_pkg::PADDR_BITS-1:0]          paddr,
	input  logic [31:0]                               pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready
);
	import smaavg_pkg::*;

	// configuration
	logic [CFG_WIDTH-1:0] win_q;
	logic [EFF_BITS-1:0]  win_eff;

	// series state
	logic [SLOT_BITS-1:0] slot_q;
	logic [SEEN_BITS-1:0] seen_q;
	logic [SUM_BITS-1:0]  sum_q;

	// beat in flight
	logic signed [SAMPLE_WIDTH-1:0] samp_q;
	logic                           last_q;
	logic                           full_q;
	logic                           neg_q;
	logic signed [OUT_WIDTH-1:0]    res_q;

	// output register
	logic                           out_valid_q;
	logic signed [OUT_WIDTH-1:0]    average_q;
	logic                           window_full_q;

	ctl_state_t state_q, state_d;
	logic       accept, do_read, do_div_wait, load_out;

	// ring memory
	logic [SAMPLE_WIDTH-1:0] ring_rdata;
	logic [SLOT_BITS:0]      old_slot;

	// datapath
	logic [SUM_BITS-1:0]  drop_val;
	logic [SUM_BITS-1:0]  new_sum;
	logic [SEEN_BITS-1:0] win_p1;
	logic [SEEN_BITS-1:0] seen_next;
	logic [SUM_BITS-1:0]  quot_signed;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	// window clamp: zero counts as one, oversize counts as the ring depth
	always_comb begin
		if (win_q == '0) begin
			win_eff = EFF_BITS'(1);
		end else if (32'(win_q) > MAX_WINDOW) begin
			win_eff = EFF_BITS'(MAX_WINDOW);
		end else begin
			win_eff = EFF_BITS'(win_q);
		end
	end

	// APB: single register, zero wait states
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINDOW_LENGTH) begin
			prdata = 32'(win_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready &&
			     paddr[2] == REG_WINDOW_LENGTH) begin
			win_q <= pwdata[CFG_WIDTH-1:0];
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		accept      = 1'b0;
		do_read     = 1'b0;
		do_div_wait = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				do_read = 1'b1;
				state_d = full_q ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				do_div_wait = 1'b1;
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// slot that leaves the window: write_slot - window, modulo ring depth
	always_comb begin
		if ({1'b0, slot_q} >= (SLOT_BITS + 1)'(win_eff)) begin
			old_slot = {1'b0, slot_q} - (SLOT_BITS + 1)'(win_eff);
		end else begin
			old_slot = {1'b0, slot_q} + (SLOT_BITS + 1)'(MAX_WINDOW) -
				   (SLOT_BITS + 1)'(win_eff);
		end
	end

	smaavg_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (do_read),
		.waddr(slot_q),
		.wdata(samp_q),
		.re   (accept),
		.raddr(old_slot[SLOT_BITS-1:0]),
		.rdata(ring_rdata)
	);

	// read-modify-write of the running sum; ring data arrives in ST_READ
	always_comb begin
		drop_val = full_q ? SUM_BITS'($signed(ring_rdata)) : '0;
		new_sum  = sum_q - drop_val + SUM_BITS'(samp_q);
	end

	// position count saturates at window + 1
	always_comb begin
		win_p1    = SEEN_BITS'(win_eff) + 1'b1;
		seen_next = seen_q;
		if (seen_q < win_p1) begin
			seen_next = seen_q + 1'b1;
		end else if (seen_q > win_p1) begin
			seen_next = win_p1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			seen_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			seen_q <= last_of_series ? '0 : seen_next;
		end else if (do_read) begin
			sum_q  <= last_q ? '0 : new_sum;
			slot_q <= (32'(slot_q) + 1 >= MAX_WINDOW) ? '0 : slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= sample;
			last_q <= last_of_series;
			full_q <= SEEN_BITS'(win_eff) <= seen_q;
		end
		if (do_read) begin
			neg_q <= new_sum[SUM_BITS-1];
			res_q <= OUT_WIDTH'(samp_q);
		end
		if (do_div_wait && div_rsp.done) begin
			res_q <= OUT_WIDTH'($signed(quot_signed));
		end
	end

	// divider gets the magnitude; sign goes back on afterward
	assign div_req.start    = do_read && full_q;
	assign div_req.dividend = new_sum[SUM_BITS-1] ? (SUM_BITS'(0) - new_sum) : new_sum;
	assign div_req.divisor  = win_eff;
	assign quot_signed      = neg_q ? (SUM_BITS'(0) - div_rsp.quotient) : div_rsp.quotient;

	smaavg_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			average_q     <= res_q;
			window_full_q <= full_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = average_q;
	assign window_full = window_full_q;

endmodule

### hw/rtl/smaavg_chk.sv
// Port-level checker for the moving average block, bound to the top level.
// Depends on smaavg_pkg and simple_moving_average.
module smaavg_chk (
	input logic                                      clk,
	input logic                                      arst_n,
	input logic                                      in_valid,
	input logic                                      in_ready,
	input logic                                      out_valid,
	input logic                                      out_ready,
	input logic signed [smaavg_pkg::OUT_WIDTH-1:0]    average,
	input logic                                      window_full
);
	import smaavg_pkg::*;

	// a held result does not change
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average) && $stable(window_full))
	else $error("held result changed");

	// one beat in flight: no accept in the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input accepted while a beat is in flight");

	// a new result appears only as the busy beat retires
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
	else $error("result appeared without a beat in flight");

	// a beat accepted with no result held does not reach the output before its read and done states
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
	else $error("result arrived too early");

endmodule

bind simple_moving_average smaavg_chk u_smaavg_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.average    (average),
	.window_full(window_full)
);

### tb/sma_window_check.sv
// Prediction and checking for the moving average block: mirrors ring, running sum and window.
// Watches the sample, average and APB channels. Depends on smaavg_pkg only.
module sma_window_check (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	input  logic                                       in_ready,
	input  logic signed [smaavg_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                       last_of_series,
	input  logic                                       out_valid,
	input  logic                                       out_ready,
	input  logic signed [smaavg_pkg::OUT_WIDTH-1:0]    average,
	input  logic                                       window_full,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic                                       pready,
	input  logic [smaavg_pkg::PADDR_BITS-1:0]          paddr,
	input  logic [31:0]                                pwdata,
	output int                                         mismatches,
	output int                                         pending,
	output int                                         results_seen,
	output int                                         means_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import smaavg_pkg::*;

	localparam logic [PADDR_BITS-1:0] WIN_ADDR = PADDR_BITS'(4 * REG_WINDOW_LENGTH);

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] average;
		logic                        window_full;
	} mean_beat_t;

	// mirrored block state
	logic signed [SAMPLE_WIDTH-1:0] price_ring [MAX_WINDOW];
	logic [SUM_BITS-1:0]            win_sum;
	logic [SLOT_BITS-1:0]           next_slot;
	int unsigned                    seen;
	logic [CFG_WIDTH-1:0]           window_reg;

	mean_beat_t expected_means[$];
	int n_err, n_res, n_mean;

	function automatic mean_beat_t advance_average(logic signed [SAMPLE_WIDTH-1:0] s,
		logic ends_series);
		int unsigned            w;
		logic                   full;
		logic [SLOT_BITS-1:0]   drop_slot;
		logic [SUM_BITS-1:0]    mag, quot;
		mean_beat_t             r;
		w = window_reg;
		if (w == 0) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		full = (seen >= w);
		if (full) begin
			drop_slot = next_slot - SLOT_BITS'(w);
			win_sum = win_sum - {{(SUM_BITS-SAMPLE_WIDTH){price_ring[drop_slot][SAMPLE_WIDTH-1]}},
				price_ring[drop_slot]};
		end
		win_sum = win_sum + {{(SUM_BITS-SAMPLE_WIDTH){s[SAMPLE_WIDTH-1]}}, s};
		price_ring[next_slot] = s;
		next_slot = next_slot + 1'b1;
		if (full) begin
			// magnitude divide, sign restored: truncation toward zero
			mag = win_sum[SUM_BITS-1] ? -win_sum : win_sum;
			quot = mag / SUM_BITS'(w);
			if (win_sum[SUM_BITS-1]) quot = -quot;
			r.average = quot[OUT_WIDTH-1:0];
			r.window_full = 1'b1;
		end else begin
			r.average = s;
			r.window_full = 1'b0;
		end
		if (seen < w + 1) seen++;
		if (seen > w + 1) seen = w + 1;
		if (ends_series) begin
			seen = 0;
			win_sum = '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mean_beat_t want;
		if (!arst_n) begin
			window_reg = WINDOW_RESET;
			win_sum = '0;
			next_slot = '0;
			seen = 0;
			expected_means.delete();
			n_err = 0;
			n_res = 0;
			n_mean = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == WIN_ADDR)
				window_reg = pwdata[CFG_WIDTH-1:0];
			if (out_valid && out_ready) begin
				n_res++;
				if (expected_means.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("%t unexpected result beat: average %0d window_full %0b",
							$realtime, average, window_full);
				end else begin
					want = expected_means.pop_front();
					if (want.window_full) n_mean++;
					if (average !== want.average || window_full !== want.window_full) begin
						n_err++;
						if (n_err <= 10)
							$display("%t mismatch: average exp %0d got %0d, window_full exp %0b got %0b",
								$realtime, want.average, average, want.window_full, window_full);
					end
				end
			end
			if (in_valid && in_ready)
				expected_means.push_back(advance_average(sample, last_of_series));
		end
		mismatches   <= n_err;
		pending      <= expected_means.size();
		results_seen <= n_res;
		means_seen   <= n_mean;
	end

endmodule

### tb/testbench.sv
// Top of the moving average testbench: clock, reset, sample stimulus, APB window writes.
// Instantiates simple_moving_average and sma_window_check; depends on smaavg_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import smaavg_pkg::*;

	// slowest path is a window mean through the divider, plus random stalls; this leaves a wide margin
	localparam int CYCLE_LIMIT = 600_000;
	localparam int PHASE_BEATS = 150;
	localparam logic [PADDR_BITS-1:0] WIN_ADDR = PADDR_BITS'(4 * REG_WINDOW_LENGTH);

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample = '0;
	logic                           last_of_series = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [OUT_WIDTH-1:0]    average;
	logic                           window_full;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [PADDR_BITS-1:0]          paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;

	int mismatches, pending, results_seen, means_seen;
	int cycle_count = 0;
	int send_idle_pct = 0;   // chance per cycle that the sample side holds off
	int recv_stall_pct = 0;  // chance per cycle that the result side stalls
	int beats_sent = 0;
	int series_sent = 0;
	int window_writes = 0;

	simple_moving_average i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.last_of_series (last_of_series),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.average        (average),
		.window_full    (window_full),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	sma_window_check i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.last_of_series (last_of_series),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.average        (average),
		.window_full    (window_full),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_seen   (results_seen),
		.means_seen     (means_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random back-pressure per the current profile
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// One sample beat. An optional random gap drops valid first; otherwise valid
	// stays high straight from the previous beat, so it gets a single update per step.
	task automatic feed_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic ends);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample <= s;
		last_of_series <= ends;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (ends) series_sent++;
	endtask

	// Stop sending and wait for every predicted result to come back.
	// pending is registered in the checker, so the value read here lags the checker's queue.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// APB write of window_length: setup cycle, then access until pready.
	// Only called once the block is idle.
	task automatic set_window(input int unsigned value);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WIN_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		window_writes++;
	endtask

	// Mostly full-range values, with a share of extremes and small values so the
	// sum hits its limits and the truncation sign rules get exercised.
	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return SAMPLE_WIDTH'(int'($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned pick_window();
		case ($urandom_range(19))
			0: return 0;
			1: return 1;
			2: return 64;
			3: return $urandom_range(127, 65);
			4, 5: return $urandom_range(40, 9);
			default: return $urandom_range(8, 2);
		endcase
	endfunction

	initial begin
		int unsigned win, eff, len;
		int phase_beats;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset window of 5: extremes in and out of a full window
		feed_sample(32'sh7FFF_FFFF, 1'b0);
		feed_sample(32'sh8000_0000, 1'b0);
		feed_sample(32'shFFFF_FFFF, 1'b0);
		feed_sample(32'sh0000_0000, 1'b0);
		feed_sample(32'sh0000_0001, 1'b0);
		feed_sample(32'sh7FFF_FFFF, 1'b0);
		feed_sample(32'sh7FFF_FFFF, 1'b0);
		feed_sample(32'sh8000_0000, 1'b1);
		// fresh series after end of series: count and sum must have cleared
		feed_sample(32'sh0000_0001, 1'b0);
		feed_sample(-32'sd1, 1'b0);
		feed_sample(32'sh0000_0002, 1'b1);
		// window zero behaves as one
		set_window(0);
		feed_sample(-32'sd7, 1'b0);
		feed_sample(32'sd7, 1'b0);
		feed_sample(-32'sd1, 1'b0);
		feed_sample(32'sh8000_0000, 1'b1);
		// negative mean truncates toward zero
		set_window(2);
		feed_sample(-32'sd3, 1'b0);
		feed_sample(-32'sd3, 1'b0);
		feed_sample(32'sd0, 1'b0);
		feed_sample(32'sd5, 1'b1);
		// window changed in the middle of a series: no recompute
		set_window(3);
		feed_sample(32'sd10, 1'b0);
		feed_sample(32'sd20, 1'b0);
		feed_sample(32'sd30, 1'b0);
		feed_sample(32'sd40, 1'b0);
		set_window(6);
		feed_sample(32'sd50, 1'b0);
		feed_sample(32'sd60, 1'b0);
		feed_sample(32'sd70, 1'b1);

		// --- random: three idling profiles ---
		for (int ph = 0; ph < 3; ph++) begin
			drain_results();
			case (ph)
				0: begin send_idle_pct = 32; recv_stall_pct = 87; end
				1: begin send_idle_pct = 87; recv_stall_pct = 32; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			phase_beats = 0;
			for (int sn = 0; phase_beats < PHASE_BEATS; sn++) begin
				// each profile opens with one of the window extremes
				if (sn == 0)
					win = (ph == 0) ? 127 : (ph == 1) ? 1 : 64;
				else if ($urandom_range(99) < 60)
					win = pick_window();
				else
					win = 0;  // keep the current setting
				if (sn == 0 || win != 0 || $urandom_range(3) == 0)
					set_window(win);
				eff = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : win;
				// mostly long enough to fill the window; some cut short
				len = ($urandom_range(99) < 15) ? $urandom_range(eff, 1)
					: eff + $urandom_range(10, 1);
				for (int k = 0; k < len; k++) begin
					// now and then the window moves mid-series
					if (k == len / 2 && len > 2 && $urandom_range(9) == 0)
						set_window($urandom_range(8, 1));
					// stray end-of-series marks break a few series early
					feed_sample(pick_sample(), k == len - 1 || $urandom_range(49) == 0);
					phase_beats++;
				end
			end
		end

		// let the last results out, then a quiet stretch to catch any stray result beats
		drain_results();
		repeat (SUM_BITS + 10) @(posedge clk);

		$display("Sent %0d samples in %0d series across %0d window_length writes.",
			beats_sent, series_sent, window_writes);
		$display("Compared %0d results, %0d of them window means.", results_seen, means_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
